// ----- hw/rtl/signed_milli_fixed_to_ascii_macros.svh -----
// ---------------------------------------------------------------------------
// signed_milli_fixed_to_ascii_macros.svh
// Assertion macros shared by the checker of the fixed-point text converter.
// ---------------------------------------------------------------------------
`ifndef SIGNED_MILLI_FIXED_TO_ASCII_MACROS_SVH
`define SIGNED_MILLI_FIXED_TO_ASCII_MACROS_SVH

// Checked on every rising edge while reset is released.
`define SMFA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SMFA_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/smfa_pkg.sv -----
// ---------------------------------------------------------------------------
// smfa_pkg
// Types, constants and the shift-and-add-three step of the text converter.
// ---------------------------------------------------------------------------
`default_nettype none

package smfa_pkg;

	localparam int VALUE_W         = 32;
	localparam int CHAR_W          = 7;
	localparam int BCD_DIGITS      = 10;
	localparam int DD_W            = VALUE_W + 4 * BCD_DIGITS;
	localparam int STEPS_PER_STAGE = 8;
	localparam int DD_STAGES       = VALUE_W / STEPS_PER_STAGE;

	localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
	localparam logic [CHAR_W-1:0] CH_POINT = 7'h2E;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 7'h39;

	typedef logic [3:0] slot_t;

	// Positions in the twelve-character text template.
	localparam slot_t SLOT_SIGN     = 4'd0;
	localparam slot_t SLOT_INT_LAST = 4'd7;
	localparam slot_t SLOT_POINT    = 4'd8;
	localparam slot_t SLOT_LAST     = 4'd11;

	typedef logic [DD_W-1:0] dd_t;

	typedef struct packed {
		logic neg;
		dd_t  dd;
	} stage_t;

	// One step of double dabble: BCD digits sit above the binary bits.
	function automatic dd_t dabble_step(dd_t x);
		dd_t y;
		y = x;
		for (int d = 0; d < BCD_DIGITS; d++) begin
			if (y[VALUE_W + 4*d +: 4] >= 4'd5) begin
				y[VALUE_W + 4*d +: 4] = y[VALUE_W + 4*d +: 4] + 4'd3;
			end
		end
		return {y[DD_W-2:0], 1'b0};
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/smfa_dabble_stage.sv -----
// ---------------------------------------------------------------------------
// smfa_dabble_stage
// One pipeline stage of the binary to BCD conversion, eight bits per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module smfa_dabble_stage (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  smfa_pkg::stage_t    in_data,
	output logic                out_valid,
	input  wire                 out_ready,
	output smfa_pkg::stage_t    out_data
);
	import smfa_pkg::*;

	stage_t nxt;
	stage_t data_s1;
	logic   valid_s1;

	always_comb begin
		nxt = in_data;
		for (int i = 0; i < STEPS_PER_STAGE; i++) begin
			nxt.dd = dabble_step(nxt.dd);
		end
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= nxt;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/smfa_serializer.sv -----
// ---------------------------------------------------------------------------
// smfa_serializer
// Holds one converted value and sends its text out one character per beat.
// ---------------------------------------------------------------------------
`default_nettype none

module smfa_serializer (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  smfa_pkg::stage_t               in_data,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic [smfa_pkg::CHAR_W-1:0]    character,
	output logic                           last
);
	import smfa_pkg::*;

	logic       busy_q;
	slot_t      pos_q;
	slot_t      first_q;
	logic [3:0] digits_q [BCD_DIGITS];
	slot_t      first_sig;
	logic [3:0] digit_idx;
	logic       out_fire;
	logic       in_fire;

	// Leading zeros of the integer part are skipped; the units digit always shows.
	always_comb begin
		first_sig = SLOT_INT_LAST;
		for (int k = 4; k < BCD_DIGITS; k++) begin
			if (in_data.dd[VALUE_W + 4*k +: 4] != 4'd0) begin
				first_sig = 4'(BCD_DIGITS - k);
			end
		end
	end

	assign out_fire = busy_q && out_ready;
	assign in_ready = !busy_q || (out_fire && (pos_q == SLOT_LAST));
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			pos_q   <= SLOT_SIGN;
			first_q <= SLOT_INT_LAST;
		end else if (in_fire) begin
			busy_q  <= 1'b1;
			pos_q   <= in_data.neg ? SLOT_SIGN : first_sig;
			first_q <= first_sig;
		end else if (out_fire) begin
			if (pos_q == SLOT_LAST) begin
				busy_q <= 1'b0;
			end else if (pos_q == SLOT_SIGN) begin
				pos_q <= first_q;
			end else begin
				pos_q <= pos_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int d = 0; d < BCD_DIGITS; d++) begin
				digits_q[d] <= in_data.dd[VALUE_W + 4*d +: 4];
			end
		end
	end

	// Integer slots map to digits nine down to three, fraction slots to two down to zero.
	assign digit_idx = (pos_q < SLOT_POINT) ? (4'(BCD_DIGITS) - pos_q)
	                                        : (4'(BCD_DIGITS + 1) - pos_q);

	always_comb begin
		case (pos_q)
			SLOT_SIGN:  character = CH_MINUS;
			SLOT_POINT: character = CH_POINT;
			default:    character = CH_ZERO + {3'b000, digits_q[digit_idx]};
		endcase
	end

	assign out_valid = busy_q;
	assign last      = (pos_q == SLOT_LAST);

endmodule

`default_nettype wire

// ----- hw/rtl/signed_milli_fixed_to_ascii.sv -----
// ---------------------------------------------------------------------------
// signed_milli_fixed_to_ascii
// Signed thousandths to decimal text, one ASCII character per output beat.
// ---------------------------------------------------------------------------
//
//  Channel | Signals                          | Direction
//  --------+----------------------------------+----------
//  input   | in_valid, in_ready, value        | in
//  output  | out_valid, out_ready, character, last | out
//
// A value passes one sign stage and four BCD stages, then reaches the
// serializer, whose output register shows its first character.
// Each value then occupies the single-character output for one beat per
// character of its text, five to twelve in all; that output register sets the rate.
// Reset clears every valid bit and the serializer state; nothing else needs it.
// A stall on the output holds the character and backs up the stages in turn,
// so no beat is lost or repeated.
`default_nettype none

module signed_milli_fixed_to_ascii (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire signed [smfa_pkg::VALUE_W-1:0] value,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic [smfa_pkg::CHAR_W-1:0]    character,
	output logic                           last
);
	import smfa_pkg::*;

	// First stage: the sign is split off and the magnitude taken. The most
	// negative value negates to itself, which as an unsigned number is right.
	logic   valid_s1;
	stage_t data_s1;
	logic   ready_s1;

	stage_t chain_data  [DD_STAGES+1];
	logic   chain_valid [DD_STAGES+1];
	logic   chain_ready [DD_STAGES+1];

	assign in_ready = !valid_s1 || ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1.neg <= value[VALUE_W-1];
			data_s1.dd  <= {{(4*BCD_DIGITS){1'b0}},
			                (value[VALUE_W-1] ? (~value + 1'b1) : value)};
		end
	end

	assign chain_data[0]  = data_s1;
	assign chain_valid[0] = valid_s1;
	assign ready_s1       = chain_ready[0];

	// Four stages of eight shift-and-add-three steps turn the 32-bit magnitude
	// into ten BCD digits; the lowest three are the fraction digits.
	for (genvar g = 0; g < DD_STAGES; g++) begin : g_dabble
		smfa_dabble_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[g]),
			.in_ready  (chain_ready[g]),
			.in_data   (chain_data[g]),
			.out_valid (chain_valid[g+1]),
			.out_ready (chain_ready[g+1]),
			.out_data  (chain_data[g+1])
		);
	end

	smfa_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chain_valid[DD_STAGES]),
		.in_ready  (chain_ready[DD_STAGES]),
		.in_data   (chain_data[DD_STAGES]),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.character (character),
		.last      (last)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/smfa_chk.sv -----
// ---------------------------------------------------------------------------
// smfa_chk
// Port-level checks of the fixed-point text converter, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "signed_milli_fixed_to_ascii_macros.svh"

module smfa_chk (
	input wire                         clk,
	input wire                         arst_n,
	input wire                         out_valid,
	input wire                         out_ready,
	input wire [smfa_pkg::CHAR_W-1:0]  character,
	input wire                         last
);
	import smfa_pkg::*;

	`SMFA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(character) && $stable(last), "output beat changed while stalled")

	`SMFA_ASSERT(a_char_legal, out_valid |-> character == CH_MINUS || character == CH_POINT || (character >= CH_ZERO && character <= CH_NINE), "illegal character")

	`SMFA_ASSERT(a_sign_first, out_valid && out_ready && !last |=> !(out_valid && character == CH_MINUS), "minus sign inside a text")

	`SMFA_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !out_valid, "output valid during reset")

endmodule

bind signed_milli_fixed_to_ascii smfa_chk u_chk (.*);

`default_nettype wire

// ----- test/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the signed thousandths to ASCII text converter.
// ---------------------------------------------------------------------------
//
// Values go in on the input channel and characters come back one beat at a
// time. Each accepted value is turned into its expected text here, either
// copied from a short typed string for the easy rows of the directed table
// or worked out by the local decimal predictor. Every output beat is checked
// against the oldest character still owed. The random part mixes full-range
// values, small magnitudes, values next to powers of ten and values next to
// the two's complement extremes. Both channels idle at random. Twice the
// receiver stops taking characters for a long stretch while the sender keeps
// offering, so that the pipeline fills up and holds its input off.
`default_nettype none

module tb_top;

	import smfa_pkg::*;

	localparam int RANDOM_ITEMS = 200;
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = 24;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DIR_ROWS     = 21;

	// One output beat as the checker sees it.
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              fin;
	} char_beat_t;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic [VALUE_W-1:0]     value;
	logic                   out_valid;
	logic                   out_ready;
	logic [CHAR_W-1:0]      character;
	logic                   last;

	// Characters still owed by the block, oldest first.
	char_beat_t text_due[$];

	int  errors;
	int  cycle_count;
	int  values_sent;
	int  negatives_sent;
	int  chars_checked;
	int  holds_done;
	bit  hold_request;

	// The directed table. A row with an empty string is checked against the
	// predictor; the others carry the text that can be read off at a glance.
	logic [VALUE_W-1:0] dir_value [DIR_ROWS] = '{
		32'd0, 32'd1, 32'hFFFF_FFFF, 32'd999, -32'sd999,
		32'd1000, -32'sd1000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
		32'd10, 32'd100, 32'd1001, -32'sd1001, 32'd9999,
		32'd1000000, -32'sd99999999, 32'd1000000000, 32'h5555_5555, 32'hAAAA_AAAA,
		32'd12345678
	};
	string dir_text [DIR_ROWS] = '{
		"0.000", "0.001", "-0.001", "0.999", "-0.999",
		"1.000", "-1.000", "2147483.647", "-2147483.648", "-2147483.647",
		"", "", "", "", "",
		"", "", "", "", "",
		""
	};

	signed_milli_fixed_to_ascii dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.character (character),
		.last      (last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Every mismatch goes through here so that the count stays honest.
	task automatic report_mismatch(input string what);
		errors++;
		$display("mismatch at cycle %0d: %s", cycle_count, what);
	endtask

	// Works out the text of one value and appends it to the owed characters.
	// The magnitude is taken modulo 2^32, which puts the most negative value
	// right without any special handling: 0 - 0x80000000 is 0x80000000.
	function automatic void queue_decimal_text(input logic [VALUE_W-1:0] v);
		logic [VALUE_W-1:0] mag;
		logic [VALUE_W-1:0] whole;
		logic [VALUE_W-1:0] frac;
		logic [3:0]         digit [BCD_DIGITS];
		int                 nd;
		nd    = 0;
		mag   = v[VALUE_W-1] ? (32'd0 - v) : v;
		whole = mag / 32'd1000;
		frac  = mag % 32'd1000;
		if (v[VALUE_W-1]) begin
			text_due.push_back('{ch: CH_MINUS, fin: 1'b0});
		end
		// A zero integer part still gives one '0' before the point.
		do begin
			digit[nd] = 4'(whole % 32'd10);
			whole     = whole / 32'd10;
			nd++;
		end while (whole != 0);
		for (int i = nd - 1; i >= 0; i--) begin
			text_due.push_back('{ch: CH_ZERO + 7'(digit[i]), fin: 1'b0});
		end
		text_due.push_back('{ch: CH_POINT, fin: 1'b0});
		text_due.push_back('{ch: CH_ZERO + 7'(frac / 32'd100), fin: 1'b0});
		text_due.push_back('{ch: CH_ZERO + 7'((frac / 32'd10) % 32'd10), fin: 1'b0});
		text_due.push_back('{ch: CH_ZERO + 7'(frac % 32'd10), fin: 1'b1});
	endfunction

	// Idle length for either side: mostly none or short, now and then long.
	function automatic int pick_gap(input bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// Offers one value, holds it until accepted, then records what it owes.
	// The task is entered and left on a falling edge, so in_valid gets one
	// assignment per edge and stays high across back-to-back beats.
	task automatic offer_value(input logic [VALUE_W-1:0] v, input string text,
			input bit quiet);
		int gap;
		gap = pick_gap(quiet);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		do @(posedge clk); while (!in_ready);
		values_sent++;
		if (v[VALUE_W-1]) begin
			negatives_sent++;
		end
		if (text.len() == 0) begin
			queue_decimal_text(v);
		end else begin
			for (int i = 0; i < text.len(); i++) begin
				text_due.push_back('{ch: 7'(text[i]), fin: i == text.len() - 1});
			end
		end
		@(negedge clk);
	endtask

	// Receiver. Stalls at random, has calm stretches where it never stalls,
	// and on request refuses every beat for a long count of cycles.
	initial begin : drain_side
		int stall;
		int rx_cycles;
		stall     = 0;
		rx_cycles = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			rx_cycles++;
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				for (int c = 1; c < HOLD_CYCLES; c++) begin
					@(negedge clk);
				end
				holds_done++;
			end else if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				stall = pick_gap((rx_cycles / 150) % 4 == 3);
			end
		end
	end

	// Output checker: each beat against the oldest owed character.
	always @(posedge clk) begin
		char_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (text_due.size() == 0) begin
				report_mismatch($sformatf("character 0x%02h with nothing owed", character));
			end else begin
				want = text_due.pop_front();
				chars_checked++;
				if (character !== want.ch) begin
					report_mismatch($sformatf("character 0x%02h, wanted 0x%02h",
						character, want.ch));
				end
				if (last !== want.fin) begin
					report_mismatch($sformatf("last %b, wanted %b on 0x%02h",
						last, want.fin, want.ch));
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d characters owed",
				cycle_count, text_due.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : stimulus
		logic [VALUE_W-1:0] v;
		int                 burst_left;
		int                 k;
		int                 base;
		errors         = 0;
		cycle_count    = 0;
		values_sent    = 0;
		negatives_sent = 0;
		chars_checked  = 0;
		holds_done     = 0;
		hold_request   = 1'b0;
		burst_left     = 0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		value          = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: extremes, signs, a zero integer part and integer parts
		// of one, four, five and seven digits.
		for (int r = 0; r < DIR_ROWS; r++) begin
			offer_value(dir_value[r], dir_text[r], 1'b0);
		end

		// Random part. Mixed shapes so that every text length turns up often.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// Twice in the run the receiver stops dead while the sender keeps
			// up a gapless stream, which backs the stages up to the input.
			if (n == 70 || n == 160) begin
				hold_request = 1'b1;
				burst_left   = 30;
			end
			case ($urandom_range(0, 3))
				0: v = $urandom;
				1: v = 32'($urandom_range(0, 19999)) - 32'd10000;
				2: begin
					k    = $urandom_range(0, 9);
					base = 1;
					for (int i = 0; i < k; i++) begin
						base = base * 10;
					end
					v = 32'(base + $urandom_range(0, 4) - 2);
					if ($urandom_range(0, 1)) begin
						v = 32'd0 - v;
					end
				end
				default: begin
					if ($urandom_range(0, 1)) begin
						v = 32'h7FFF_FFFF - 32'($urandom_range(0, 3));
					end else begin
						v = 32'h8000_0000 + 32'($urandom_range(0, 3));
					end
				end
			endcase
			offer_value(v, "", burst_left > 0);
			if (burst_left > 0) begin
				burst_left--;
			end
		end
		in_valid <= 1'b0;

		while (text_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("converted %0d values (%0d negative), %0d characters checked",
			values_sent, negatives_sent, chars_checked);
		$display("random idling on both sides, %0d long receiver holds, %0d mismatches",
			holds_done, errors);
		if (errors == 0 && text_due.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- signed_milli_fixed_to_ascii.f -----
+incdir+hw/rtl
hw/rtl/smfa_pkg.sv
hw/rtl/smfa_dabble_stage.sv
hw/rtl/smfa_serializer.sv
hw/rtl/signed_milli_fixed_to_ascii.sv
hw/rtl/smfa_chk.sv
test/tb_top.sv
